### hw/rtl/i2c_register_transaction_master_defines.svh
// assertion macros shared by the checker
// all of them sample on clk and are held off while rst is high
`ifndef I2C_REGISTER_TRANSACTION_MASTER_DEFINES_SVH
`define I2C_REGISTER_TRANSACTION_MASTER_DEFINES_SVH

// same-cycle implication
`define I2C_RTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define I2C_RTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/i2c_rtm_pkg.sv
`default_nettype none

package i2c_rtm_pkg;

  localparam int WBUF_DEPTH = 8;
  localparam int WBUF_AW = (WBUF_DEPTH > 1) ? $clog2(WBUF_DEPTH) : 1;
  localparam int DIDX_W = $clog2(WBUF_DEPTH + 1);

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TIMEOUT  = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_HOLD,
    PH_ST_LOW,
    PH_TX_SET,
    PH_TX_HIGH,
    PH_TX_LOW,
    PH_ACK_REL,
    PH_ACK_WAIT,
    PH_ACK_PULSE,
    PH_RS_PRE,
    PH_RS_HIGH,
    PH_RX_LOW,
    PH_RX_HIGH,
    PH_K_LOW,
    PH_K_HIGH,
    PH_P_LOW,
    PH_P_HIGH,
    PH_P_END
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ADDR  = 2'd0,
    KIND_REG   = 2'd1,
    KIND_RADDR = 2'd2,
    KIND_DATA  = 2'd3
  } byte_kind_t;

  typedef struct packed {
    logic scl;
    logic en;
    logic sda;
  } lines_t;

  typedef struct packed {
    logic               en;
    logic [WBUF_AW-1:0] addr;
    logic [7:0]         data;
  } wbuf_wr_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [2:0] load_index;
    logic [7:0] load_value;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_enable;
    logic       sda_level;
    logic [7:0] received_byte;
    logic       received_valid;
    logic       received_last;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/i2c_rtm_wbuf.sv
`default_nettype none

module i2c_rtm_wbuf
  import i2c_rtm_pkg::*;
(
  input  wire logic               clk,
  input  wire wbuf_wr_t           wr,
  input  wire logic [WBUF_AW-1:0] rd_addr,
  output logic [7:0]              rd_data
);

  logic [7:0] mem [WBUF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // a load on the same tick is seen by the read
  assign rd_data = (wr.en && (wr.addr == rd_addr)) ? wr.data : mem[rd_addr];

endmodule

`default_nettype wire

### hw/rtl/i2c_rtm_seq.sv
`default_nettype none

module i2c_rtm_seq
  import i2c_rtm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire in_item_t           item,
  input  wire logic [7:0]         ack_timeout,
  input  wire logic [7:0]         rd_data,
  output wbuf_wr_t                wr,
  output logic [WBUF_AW-1:0]      rd_addr,
  output out_item_t               res
);

  phase_t            phase, phase_next;
  byte_kind_t        byte_kind, byte_kind_next;
  logic [2:0]        bit_counter, bit_counter_next;
  logic [7:0]        bytes_left, bytes_left_next;
  logic [7:0]        shift_register, shift_register_next;
  logic [7:0]        wait_counter, wait_counter_next;
  logic [7:0]        saved_device, saved_device_next;
  logic [7:0]        saved_register, saved_register_next;
  logic              read_mode, read_mode_next;
  lines_t            line_levels, line_levels_next;
  logic [DIDX_W-1:0] data_index, data_index_next;
  logic [1:0]        end_code, end_code_next;

  logic       too_long;
  logic       begin_op;
  logic       do_ack;
  logic [7:0] data_value;
  logic       last_byte;

  assign too_long  = (item.op == OP_WRITE) &&
                     ({1'b0, item.byte_count} > 9'(WBUF_DEPTH));
  assign begin_op  = (item.op == OP_WRITE) || (item.op == OP_READ);
  assign last_byte = (bytes_left == 8'd1);

  assign wr.en   = step && (item.op == OP_LOAD) &&
                   ({6'd0, item.load_index} < 9'(WBUF_DEPTH));
  assign wr.addr = WBUF_AW'(item.load_index);
  assign wr.data = item.load_value;

  assign rd_addr    = data_index[WBUF_AW-1:0];
  assign data_value = (data_index < DIDX_W'(WBUF_DEPTH)) ? rd_data : 8'd0;

  // next state
  always_comb begin
    phase_next          = phase;
    byte_kind_next      = byte_kind;
    bit_counter_next    = bit_counter;
    bytes_left_next     = bytes_left;
    shift_register_next = shift_register;
    wait_counter_next   = wait_counter;
    saved_device_next   = saved_device;
    saved_register_next = saved_register;
    read_mode_next      = read_mode;
    data_index_next     = data_index;
    end_code_next       = end_code;
    do_ack              = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (!too_long && begin_op) begin
          saved_device_next   = item.device_address;
          saved_register_next = item.register_address;
          bytes_left_next     = item.byte_count;
          read_mode_next      = (item.op == OP_READ);
          data_index_next     = '0;
          wait_counter_next   = 8'd0;
          end_code_next       = STAT_OK;
          phase_next          = PH_ST_HOLD;
        end
      end
      PH_RS_PRE:  phase_next = PH_RS_HIGH;
      PH_RS_HIGH: phase_next = PH_ST_HOLD;
      PH_ST_HOLD: phase_next = PH_ST_LOW;
      PH_ST_LOW: begin
        // second start of a read carries the read address
        if (byte_kind == KIND_REG) begin
          shift_register_next = saved_device + 8'd1;
          byte_kind_next      = KIND_RADDR;
        end else begin
          shift_register_next = saved_device;
          byte_kind_next      = KIND_ADDR;
        end
        bit_counter_next = 3'd0;
        phase_next       = PH_TX_SET;
      end
      PH_TX_SET:  phase_next = PH_TX_HIGH;
      PH_TX_HIGH: phase_next = PH_TX_LOW;
      PH_TX_LOW: begin
        shift_register_next = {shift_register[6:0], 1'b0};
        if (bit_counter == 3'd7) begin
          bit_counter_next = 3'd0;
          phase_next       = PH_ACK_REL;
        end else begin
          bit_counter_next = bit_counter + 3'd1;
          phase_next       = PH_TX_SET;
        end
      end
      PH_ACK_REL: begin
        wait_counter_next = 8'd0;
        if ((byte_kind == KIND_ADDR) || (byte_kind == KIND_DATA)) begin
          phase_next = PH_ACK_WAIT;
        end else begin
          phase_next = PH_ACK_PULSE;
        end
      end
      PH_ACK_WAIT: begin
        if (!item.sda_sample) begin
          do_ack = 1'b1;
        end else if (wait_counter >= ack_timeout) begin
          end_code_next = STAT_TIMEOUT;
          phase_next    = PH_P_LOW;
        end else begin
          wait_counter_next = wait_counter + 8'd1;
        end
      end
      PH_ACK_PULSE: do_ack = 1'b1;
      PH_RX_LOW:    phase_next = PH_RX_HIGH;
      PH_RX_HIGH: begin
        shift_register_next = {shift_register[6:0], item.sda_sample};
        if (bit_counter == 3'd7) begin
          bit_counter_next = 3'd0;
          phase_next       = PH_K_LOW;
        end else begin
          bit_counter_next = bit_counter + 3'd1;
          phase_next       = PH_RX_LOW;
        end
      end
      PH_K_LOW: phase_next = PH_K_HIGH;
      PH_K_HIGH: begin
        bytes_left_next = bytes_left - 8'd1;
        if (last_byte) begin
          end_code_next = STAT_OK;
          phase_next    = PH_P_LOW;
        end else begin
          shift_register_next = 8'd0;
          phase_next          = PH_RX_LOW;
        end
      end
      PH_P_LOW:  phase_next = PH_P_HIGH;
      PH_P_HIGH: phase_next = PH_P_END;
      default: begin
        byte_kind_next = KIND_ADDR;
        phase_next     = PH_IDLE;
      end
    endcase

    // what follows an acknowledge depends on the byte just sent
    if (do_ack) begin
      case (byte_kind)
        KIND_ADDR: begin
          shift_register_next = saved_register;
          byte_kind_next      = KIND_REG;
          bit_counter_next    = 3'd0;
          phase_next          = PH_TX_SET;
        end
        KIND_REG: begin
          if (read_mode) begin
            phase_next = PH_RS_PRE;
          end else if (bytes_left == 8'd0) begin
            end_code_next = STAT_OK;
            phase_next    = PH_P_LOW;
          end else begin
            shift_register_next = data_value;
            byte_kind_next      = KIND_DATA;
            bit_counter_next    = 3'd0;
            data_index_next     = data_index + DIDX_W'(1);
            phase_next          = PH_TX_SET;
          end
        end
        KIND_RADDR: begin
          if (bytes_left == 8'd0) begin
            end_code_next = STAT_OK;
            phase_next    = PH_P_LOW;
          end else begin
            bit_counter_next    = 3'd0;
            shift_register_next = 8'd0;
            phase_next          = PH_RX_LOW;
          end
        end
        default: begin
          bytes_left_next = bytes_left - 8'd1;
          if (last_byte) begin
            end_code_next = STAT_OK;
            phase_next    = PH_P_LOW;
          end else begin
            shift_register_next = data_value;
            byte_kind_next      = KIND_DATA;
            bit_counter_next    = 3'd0;
            data_index_next     = data_index + DIDX_W'(1);
            phase_next          = PH_TX_SET;
          end
        end
      endcase
    end
  end

  // lines and result fields
  always_comb begin
    line_levels_next   = line_levels;
    res                = '0;
    res.busy_res       = 1'b1;

    case (phase)
      PH_IDLE: begin
        res.busy_res = 1'b0;
        if (too_long) begin
          res.done_res = 1'b1;
          res.status   = STAT_TOO_LONG;
        end else if (begin_op) begin
          res.busy_res     = 1'b1;
          line_levels_next = '{scl: 1'b1, en: 1'b1, sda: 1'b1};
        end
      end
      PH_RS_PRE:    line_levels_next = '{scl: 1'b0, en: 1'b1, sda: 1'b1};
      PH_RS_HIGH:   line_levels_next = '{scl: 1'b1, en: 1'b1, sda: 1'b1};
      PH_ST_HOLD:   line_levels_next = '{scl: 1'b1, en: 1'b1, sda: 1'b0};
      PH_ST_LOW:    line_levels_next = '{scl: 1'b0, en: 1'b1, sda: 1'b0};
      PH_TX_SET:    line_levels_next = '{scl: 1'b0, en: 1'b1, sda: shift_register[7]};
      PH_TX_HIGH:   line_levels_next = '{scl: 1'b1, en: 1'b1, sda: shift_register[7]};
      PH_TX_LOW:    line_levels_next = '{scl: 1'b0, en: 1'b1, sda: shift_register[7]};
      PH_ACK_REL:   line_levels_next = '{scl: 1'b0, en: 1'b0, sda: 1'b1};
      PH_ACK_WAIT:  line_levels_next = '{scl: 1'b1, en: 1'b0, sda: 1'b1};
      PH_ACK_PULSE: line_levels_next = '{scl: 1'b1, en: 1'b0, sda: 1'b1};
      PH_RX_LOW:    line_levels_next = '{scl: 1'b0, en: 1'b0, sda: 1'b1};
      PH_RX_HIGH: begin
        line_levels_next = '{scl: 1'b1, en: 1'b0, sda: 1'b1};
        if (bit_counter == 3'd7) begin
          res.received_byte  = {shift_register[6:0], item.sda_sample};
          res.received_valid = 1'b1;
          res.received_last  = last_byte;
        end
      end
      // nack after the final byte, ack otherwise
      PH_K_LOW:  line_levels_next = '{scl: 1'b0, en: 1'b1, sda: last_byte};
      PH_K_HIGH: line_levels_next = '{scl: 1'b1, en: 1'b1, sda: last_byte};
      PH_P_LOW:  line_levels_next = '{scl: 1'b0, en: 1'b1, sda: 1'b0};
      PH_P_HIGH: line_levels_next = '{scl: 1'b1, en: 1'b1, sda: 1'b0};
      default: begin
        line_levels_next = '{scl: 1'b1, en: 1'b1, sda: 1'b1};
        res.busy_res     = 1'b0;
        res.done_res     = 1'b1;
        res.status       = end_code;
      end
    endcase

    res.scl_level        = line_levels_next.scl;
    res.sda_drive_enable = line_levels_next.en;
    res.sda_level        = line_levels_next.sda | ~line_levels_next.en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_kind      <= KIND_ADDR;
      bit_counter    <= 3'd0;
      bytes_left     <= 8'd0;
      shift_register <= 8'd0;
      wait_counter   <= 8'd0;
      saved_device   <= 8'd0;
      saved_register <= 8'd0;
      read_mode      <= 1'b0;
      line_levels    <= '{scl: 1'b1, en: 1'b1, sda: 1'b1};
      data_index     <= '0;
      end_code       <= STAT_OK;
    end else if (step) begin
      phase          <= phase_next;
      byte_kind      <= byte_kind_next;
      bit_counter    <= bit_counter_next;
      bytes_left     <= bytes_left_next;
      shift_register <= shift_register_next;
      wait_counter   <= wait_counter_next;
      saved_device   <= saved_device_next;
      saved_register <= saved_register_next;
      read_mode      <= read_mode_next;
      line_levels    <= line_levels_next;
      data_index     <= data_index_next;
      end_code       <= end_code_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/i2c_register_transaction_master.sv
// I2C register transaction master.
// Each input item is one bit-timing tick from an external prescaler: op selects a
// plain tick, a write-buffer load, or the start of a register write or read.
// Every accepted item yields exactly one output item carrying the SCL/SDA line
// levels for that tick, any received byte, and busy/done/status flags.
// The user writes the ack_timeout register through cfg_write/cfg_data only while
// idle; the block itself does not enforce this. The output item is valid the
// cycle after its input item is accepted. Throughput: one item per cycle while
// in_stall is low; the sequencer state register updates once per accepted item.
// Stall: while out_valid is high and out_stall is asserted the output item holds
// and in_stall is raised, so no input item is taken until the output drains.
// Reset (rst, synchronous): sequencer idle, SCL high with SDA driven high,
// ack_timeout back to 250, output register empty. Write buffer contents are
// left as they were and must be loaded before a write uses them.
`default_nettype none

module i2c_register_transaction_master
  import i2c_rtm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data
);

  logic               step;
  logic [7:0]         ack_timeout;
  wbuf_wr_t           wr;
  logic [WBUF_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  out_item_t          res;

  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_write) begin
      ack_timeout <= cfg_data;
    end
  end

  i2c_rtm_wbuf u_wbuf (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  i2c_rtm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_item),
    .ack_timeout (ack_timeout),
    .rd_data     (rd_data),
    .wr          (wr),
    .rd_addr     (rd_addr),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/i2c_rtm_chk.sv
`default_nettype none

`include "i2c_register_transaction_master_defines.svh"

module i2c_rtm_chk
  import i2c_rtm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  `I2C_RTM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled output item changed")

  `I2C_RTM_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid, "input stalled with empty output register")

  `I2C_RTM_ASSERT_NOW(a_done_not_busy, out_valid && out_item.done_res, !out_item.busy_res, "done item still busy")

  `I2C_RTM_ASSERT_NOW(a_status_with_done, out_valid && (out_item.status != STAT_OK), out_item.done_res, "error status without done")

  // a byte completes on a high clock with SDA released
  `I2C_RTM_ASSERT_NOW(a_rx_on_scl_high, out_valid && out_item.received_valid, out_item.scl_level && !out_item.sda_drive_enable, "received byte outside released high clock")

endmodule

bind i2c_register_transaction_master i2c_rtm_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
